// ===== hdl/kvi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvi_pkg
// shared types, constants and the unit normal table for the keyframe vertex
// interpolator
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int NORMAL_COUNT = 162;
  localparam int CFG_W        = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int QUO_W        = 17;
  localparam int REM_W        = 14;
  localparam int DIV_STEPS    = 3;
  localparam int DIV_STAGES   = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_FIRST    = 2;
  localparam int LAST_STAGE   = DIV_FIRST + DIV_STAGES;
  localparam int RES_FIRST    = 4;

  localparam logic [16:0] BLEND_ONE = 17'd65536;
  localparam logic [16:0] TEX_MAX   = 17'd131071;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_FIRST   = 3'd0,
    REG_OFFSET_FIRST  = 3'd1,
    REG_SCALE_SECOND  = 3'd2,
    REG_OFFSET_SECOND = 3'd3,
    REG_BLEND         = 3'd4,
    REG_SKIN_WIDTH    = 3'd5,
    REG_SKIN_HEIGHT   = 3'd6
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] SCALE_RESET  = 48'h1000_1000_1000;
  localparam logic [12:0]      SKIN_RESET   = 13'd256;

  localparam logic signed [15:0] Z    = 16'sd0;
  localparam logic signed [15:0] C526 = 16'sd17227;
  localparam logic signed [15:0] C851 = 16'sd27874;
  localparam logic signed [15:0] C443 = 16'sd14512;
  localparam logic signed [15:0] C239 = 16'sd7827;
  localparam logic signed [15:0] C864 = 16'sd28318;
  localparam logic signed [15:0] C295 = 16'sd9674;
  localparam logic signed [15:0] C955 = 16'sd31307;
  localparam logic signed [15:0] C309 = 16'sd10126;
  localparam logic signed [15:0] C500 = 16'sd16384;
  localparam logic signed [15:0] C809 = 16'sd26510;
  localparam logic signed [15:0] C162 = 16'sd5323;
  localparam logic signed [15:0] C263 = 16'sd8614;
  localparam logic signed [15:0] C951 = 16'sd31164;
  localparam logic signed [15:0] C1K  = 16'sd32767;
  localparam logic signed [15:0] CN1K = 16'sh8000;
  localparam logic signed [15:0] C148 = 16'sd4837;
  localparam logic signed [15:0] C717 = 16'sd23480;
  localparam logic signed [15:0] C682 = 16'sd22339;
  localparam logic signed [15:0] C588 = 16'sd19261;
  localparam logic signed [15:0] C425 = 16'sd13937;
  localparam logic signed [15:0] C688 = 16'sd22551;

  // x in [47:32], y in [31:16], z in [15:0]
  localparam logic [47:0] NORMAL_ROM [NORMAL_COUNT] = '{
    {-C526,Z,C851},{-C443,C239,C864},{-C295,Z,C955},{-C309,C500,C809},
    {-C162,C263,C951},{Z,Z,C1K},{Z,C851,C526},{-C148,C717,C682},
    {C148,C717,C682},{Z,C526,C851},{C309,C500,C809},{C526,Z,C851},
    {C295,Z,C955},{C443,C239,C864},{C162,C263,C951},{-C682,C148,C717},
    {-C809,C309,C500},{-C588,C425,C688},{-C851,C526,Z},{-C864,C443,C239},
    {-C717,C682,C148},{-C688,C588,C425},{-C500,C809,C309},{-C239,C864,C443},
    {-C425,C688,C588},{-C717,C682,-C148},{-C500,C809,-C309},{-C526,C851,Z},
    {Z,C851,-C526},{-C239,C864,-C443},{Z,C955,-C295},{-C263,C951,-C162},
    {Z,C1K,Z},{Z,C955,C295},{-C263,C951,C162},{C239,C864,C443},
    {C263,C951,C162},{C500,C809,C309},{C239,C864,-C443},{C263,C951,-C162},
    {C500,C809,-C309},{C851,C526,Z},{C717,C682,C148},{C717,C682,-C148},
    {C526,C851,Z},{C425,C688,C588},{C864,C443,C239},{C688,C588,C425},
    {C809,C309,C500},{C682,C148,C717},{C588,C425,C688},{C955,C295,Z},
    {C1K,Z,Z},{C951,C162,C263},{C851,-C526,Z},{C955,-C295,Z},
    {C864,-C443,C239},{C951,-C162,C263},{C809,-C309,C500},{C682,-C148,C717},
    {C851,Z,C526},{C864,C443,-C239},{C809,C309,-C500},{C951,C162,-C263},
    {C526,Z,-C851},{C682,C148,-C717},{C682,-C148,-C717},{C851,Z,-C526},
    {C809,-C309,-C500},{C864,-C443,-C239},{C951,-C162,-C263},{C148,C717,-C682},
    {C309,C500,-C809},{C425,C688,-C588},{C443,C239,-C864},{C588,C425,-C688},
    {C688,C588,-C425},{-C148,C717,-C682},{-C309,C500,-C809},{Z,C526,-C851},
    {-C526,Z,-C851},{-C443,C239,-C864},{-C295,Z,-C955},{-C162,C263,-C951},
    {Z,Z,CN1K},{C295,Z,-C955},{C162,C263,-C951},{-C443,-C239,-C864},
    {-C309,-C500,-C809},{-C162,-C263,-C951},{Z,-C851,-C526},{-C148,-C717,-C682},
    {C148,-C717,-C682},{Z,-C526,-C851},{C309,-C500,-C809},{C443,-C239,-C864},
    {C162,-C263,-C951},{C239,-C864,-C443},{C500,-C809,-C309},{C425,-C688,-C588},
    {C717,-C682,-C148},{C688,-C588,-C425},{C588,-C425,-C688},{Z,-C955,-C295},
    {Z,CN1K,Z},{C263,-C951,-C162},{Z,-C851,C526},{Z,-C955,C295},
    {C239,-C864,C443},{C263,-C951,C162},{C500,-C809,C309},{C717,-C682,C148},
    {C526,-C851,Z},{-C239,-C864,-C443},{-C500,-C809,-C309},{-C263,-C951,-C162},
    {-C851,-C526,Z},{-C717,-C682,-C148},{-C717,-C682,C148},{-C526,-C851,Z},
    {-C500,-C809,C309},{-C239,-C864,C443},{-C263,-C951,C162},{-C864,-C443,C239},
    {-C809,-C309,C500},{-C688,-C588,C425},{-C682,-C148,C717},{-C443,-C239,C864},
    {-C588,-C425,C688},{-C309,-C500,C809},{-C148,-C717,C682},{-C425,-C688,C588},
    {-C162,-C263,C951},{C443,-C239,C864},{C162,-C263,C951},{C309,-C500,C809},
    {C148,-C717,C682},{Z,-C526,C851},{C425,-C688,C588},{C588,-C425,C688},
    {C688,-C588,C425},{-C955,C295,Z},{-C951,C162,C263},{CN1K,Z,Z},
    {-C851,Z,C526},{-C955,-C295,Z},{-C951,-C162,C263},{-C864,C443,-C239},
    {-C951,C162,-C263},{-C809,C309,-C500},{-C864,-C443,-C239},{-C951,-C162,-C263},
    {-C809,-C309,-C500},{-C682,C148,-C717},{-C682,-C148,-C717},{-C851,Z,-C526},
    {-C688,C588,-C425},{-C588,C425,-C688},{-C425,C688,-C588},{-C425,-C688,-C588},
    {-C588,-C425,-C688},{-C688,-C588,-C425}
  };

  typedef struct packed {
    logic [7:0]  first_x;
    logic [7:0]  first_y;
    logic [7:0]  first_z;
    logic [7:0]  first_normal;
    logic [7:0]  second_x;
    logic [7:0]  second_y;
    logic [7:0]  second_z;
    logic [7:0]  second_normal;
    logic [11:0] texel_s;
    logic [11:0] texel_t;
    logic        last;
  } vin_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] nlo;
    logic [QUO_W-1:0] quo;
    logic             sat;
  } div_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last;
  } res_t;

endpackage

// ===== hdl/keyframe_vertex_interpolator.sv =====
`timescale 1ns / 1ps
// throughput: one item per cycle while out_stall is low; depth is set by the
//   texel divider, 3 quotient bits per stage over 6 stages, with the position
//   path padded to match
// reset: rst clears all stage valid bits and loads register defaults
//   (unit scales, zero offsets, blend 0, 256x256 skin)
// ----------------------------------------------------------------------------
// keyframe_vertex_interpolator
// decodes and blends two keyframe vertices and normals, normalizes texels
// ----------------------------------------------------------------------------
module keyframe_vertex_interpolator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kvi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kvi_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    first_x,
  input  logic [7:0]                    first_y,
  input  logic [7:0]                    first_z,
  input  logic [7:0]                    first_normal,
  input  logic [7:0]                    second_x,
  input  logic [7:0]                    second_y,
  input  logic [7:0]                    second_z,
  input  logic [7:0]                    second_normal,
  input  logic [11:0]                   texel_s,
  input  logic [11:0]                   texel_t,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [23:0]            pos_x,
  output logic signed [23:0]            pos_y,
  output logic signed [23:0]            pos_z,
  output logic signed [15:0]            norm_x,
  output logic signed [15:0]            norm_y,
  output logic signed [15:0]            norm_z,
  output logic [16:0]                   tex_u,
  output logic [16:0]                   tex_v,
  output logic                          last_out
);

  localparam int LS = kvi_pkg::LAST_STAGE;
  localparam int DF = kvi_pkg::DIV_FIRST;
  localparam int RF = kvi_pkg::RES_FIRST;
  localparam logic signed [27:0] POS_MAX = 28'sd8388607;
  localparam logic signed [27:0] POS_MIN = -28'sd8388608;

  logic [kvi_pkg::CFG_W-1:0] scale_first, offset_first, scale_second, offset_second;
  logic [16:0] blend;
  logic [12:0] skin_width, skin_height;

  logic en;
  logic vld [1:LS];

  kvi_pkg::vin_t s1;
  logic [16:0] f2;

  logic signed [24:0] va2 [3];
  logic signed [24:0] vb2 [3];
  logic signed [15:0] na2 [3];
  logic signed [15:0] nb2 [3];
  logic signed [24:0] va3 [3];
  logic signed [15:0] na3 [3];
  logic signed [43:0] pp3 [3];
  logic signed [34:0] np3 [3];
  logic last2, last3;

  kvi_pkg::res_t res [RF:LS];
  kvi_pkg::div_t div_u [DF:LS];
  kvi_pkg::div_t div_v [DF:LS];

  // the whole pipe advances unless the output item is held
  assign en       = !(vld[LS] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_first   <= kvi_pkg::SCALE_RESET;
      offset_first  <= '0;
      scale_second  <= kvi_pkg::SCALE_RESET;
      offset_second <= '0;
      blend         <= '0;
      skin_width    <= kvi_pkg::SKIN_RESET;
      skin_height   <= kvi_pkg::SKIN_RESET;
    end else if (cfg_we) begin
      case (kvi_pkg::cfg_reg_t'(cfg_index))
        kvi_pkg::REG_SCALE_FIRST:   scale_first   <= cfg_data;
        kvi_pkg::REG_OFFSET_FIRST:  offset_first  <= cfg_data;
        kvi_pkg::REG_SCALE_SECOND:  scale_second  <= cfg_data;
        kvi_pkg::REG_OFFSET_SECOND: offset_second <= cfg_data;
        kvi_pkg::REG_BLEND:         blend         <= cfg_data[16:0];
        kvi_pkg::REG_SKIN_WIDTH:    skin_width    <= cfg_data[12:0];
        kvi_pkg::REG_SKIN_HEIGHT:   skin_height   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LS; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int i = 2; i <= LS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= '{first_x, first_y, first_z, first_normal, second_x, second_y,
              second_z, second_normal, texel_s, texel_t, last_in};
    end
  end

  // stage 2: decode both keyframes, normal table lookup
  logic [7:0] qa1 [3];
  logic [7:0] qb1 [3];
  assign qa1[0] = s1.first_x;
  assign qa1[1] = s1.first_y;
  assign qa1[2] = s1.first_z;
  assign qb1[0] = s1.second_x;
  assign qb1[1] = s1.second_y;
  assign qb1[2] = s1.second_z;

  logic [47:0] nva1, nvb1;
  assign nva1 = (s1.first_normal < 8'(kvi_pkg::NORMAL_COUNT)) ?
                kvi_pkg::NORMAL_ROM[s1.first_normal] : '0;
  assign nvb1 = (s1.second_normal < 8'(kvi_pkg::NORMAL_COUNT)) ?
                kvi_pkg::NORMAL_ROM[s1.second_normal] : '0;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [15:0] sca, scb, ofa, ofb;
    logic signed [8:0]  qa, qb;
    logic signed [24:0] va_n, vb_n;
    logic signed [25:0] diff;
    logic signed [16:0] ndiff;
    logic signed [17:0] fs;
    logic signed [43:0] rp;
    logic signed [34:0] rn;
    logic signed [27:0] psum;
    logic signed [18:0] nsum;

    assign sca  = scale_first[16*a +: 16];
    assign scb  = scale_second[16*a +: 16];
    assign ofa  = offset_first[16*a +: 16];
    assign ofb  = offset_second[16*a +: 16];
    assign qa   = {1'b0, qa1[a]};
    assign qb   = {1'b0, qb1[a]};
    assign va_n = sca * qa + $signed({ofa[15], ofa, 8'd0});
    assign vb_n = scb * qb + $signed({ofb[15], ofb, 8'd0});

    always_ff @(posedge clk) begin
      if (en) begin
        va2[a] <= va_n;
        vb2[a] <= vb_n;
        na2[a] <= nva1[32-16*a +: 16];
        nb2[a] <= nvb1[32-16*a +: 16];
      end
    end

    // stage 3: difference times blend factor
    assign diff  = {vb2[a][24], vb2[a]} - {va2[a][24], va2[a]};
    assign ndiff = {nb2[a][15], nb2[a]} - {na2[a][15], na2[a]};
    assign fs    = {1'b0, f2};

    always_ff @(posedge clk) begin
      if (en) begin
        va3[a] <= va2[a];
        na3[a] <= na2[a];
        pp3[a] <= diff * fs;
        np3[a] <= ndiff * fs;
      end
    end

    // stage 4: round half up, add base, saturate positions
    assign rp   = pp3[a] + 44'sd32768;
    assign rn   = np3[a] + 35'sd32768;
    assign psum = {{3{va3[a][24]}}, va3[a]} + rp[43:16];
    assign nsum = {{3{na3[a][15]}}, na3[a]} + rn[34:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2    <= (blend > kvi_pkg::BLEND_ONE) ? kvi_pkg::BLEND_ONE : blend;
      last2 <= s1.last;
      last3 <= last2;
    end
  end

  function automatic logic signed [23:0] sat_pos(input logic signed [27:0] p);
    logic signed [23:0] r;
    if (p > POS_MAX)      r = POS_MAX[23:0];
    else if (p < POS_MIN) r = POS_MIN[23:0];
    else                  r = p[23:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      res[RF].pos_x  <= sat_pos(g_axis[0].psum);
      res[RF].pos_y  <= sat_pos(g_axis[1].psum);
      res[RF].pos_z  <= sat_pos(g_axis[2].psum);
      res[RF].norm_x <= g_axis[0].nsum[15:0];
      res[RF].norm_y <= g_axis[1].nsum[15:0];
      res[RF].norm_z <= g_axis[2].nsum[15:0];
      res[RF].last   <= last3;
      for (int i = RF + 1; i <= LS; i++) res[i] <= res[i-1];
    end
  end

  // texel divider: ((2s+1)*65536 + size) / (2*size), restoring, 3 bits a stage
  function automatic kvi_pkg::div_t div_start(input logic [11:0] texel,
                                               input logic [12:0] size);
    kvi_pkg::div_t d;
    logic [28:0] num;
    logic [13:0] den;
    num   = {texel, 1'b1, 16'd0} + {16'd0, size};
    den   = {size, 1'b0};
    d.sat = (size == '0) || ({2'b00, num[28:17]} >= den);
    d.rem = {2'b00, num[28:17]};
    d.nlo = num[16:0];
    d.quo = '0;
    return d;
  endfunction

  function automatic kvi_pkg::div_t div_run(input kvi_pkg::div_t din, input int stage,
                                            input logic [12:0] size);
    kvi_pkg::div_t d;
    logic [kvi_pkg::REM_W:0] t;
    logic [kvi_pkg::REM_W:0] den;
    d   = din;
    den = {1'b0, size, 1'b0};
    for (int j = 0; j < kvi_pkg::DIV_STEPS; j++) begin
      if (stage * kvi_pkg::DIV_STEPS + j < kvi_pkg::QUO_W) begin
        t = {d.rem, d.nlo[kvi_pkg::QUO_W-1]};
        d.nlo = {d.nlo[kvi_pkg::QUO_W-2:0], 1'b0};
        if (t >= den) begin
          t = t - den;
          d.quo = {d.quo[kvi_pkg::QUO_W-2:0], 1'b1};
        end else begin
          d.quo = {d.quo[kvi_pkg::QUO_W-2:0], 1'b0};
        end
        d.rem = t[kvi_pkg::REM_W-1:0];
      end
    end
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      div_u[DF] <= div_start(s1.texel_s, skin_width);
      div_v[DF] <= div_start(s1.texel_t, skin_height);
    end
  end

  for (genvar k = DF + 1; k <= LS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        div_u[k] <= div_run(div_u[k-1], k - DF - 1, skin_width);
        div_v[k] <= div_run(div_v[k-1], k - DF - 1, skin_height);
      end
    end
  end

  assign out_valid = vld[LS];
  assign pos_x     = res[LS].pos_x;
  assign pos_y     = res[LS].pos_y;
  assign pos_z     = res[LS].pos_z;
  assign norm_x    = res[LS].norm_x;
  assign norm_y    = res[LS].norm_y;
  assign norm_z    = res[LS].norm_z;
  assign last_out  = res[LS].last;
  assign tex_u     = div_u[LS].sat ? kvi_pkg::TEX_MAX : div_u[LS].quo;
  assign tex_v     = div_v[LS].sat ? kvi_pkg::TEX_MAX : div_v[LS].quo;

endmodule
